// File: hdl/dom_pkg.sv
// Package for the debris outflow block: payload types, widths and codes.
// Used by dom_ctrl, dom_datapath and debris_outflow_minimization.
`timescale 1ns / 1ps
package dom_pkg;

  // Cells in the neighbourhood: the center and four neighbours
  localparam int NBHD      = 5;
  // Level = altitude + thickness, signed
  localparam int LVL_W     = 34;
  // Amount = thickness - epsilon, signed
  localparam int AMT_W     = 32;
  // Round sum of amount and up to five levels, signed
  localparam int SUM_W     = 37;
  // Divider shift register, four quotient bits per step
  localparam int DIV_BITS  = 4;
  localparam int DIV_W     = 40;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  // Average and difference, signed
  localparam int AVG_W     = 38;
  // Split of the difference for the two partial products
  localparam int LO_W      = 19;
  localparam int HI_W      = AVG_W - LO_W;
  localparam int REL_W     = 17;
  localparam int EPS_W     = 16;
  localparam int PP_W      = LO_W + REL_W;
  localparam int PROD_W    = HI_W + REL_W + LO_W + 1;
  localparam int FLOW_W    = 31;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
  localparam logic [REL_W-1:0] REL_RESET = 17'd32768;

  // Configuration register indexes
  localparam logic CFG_EPSILON    = 1'b0;
  localparam logic CFG_RELAXATION = 1'b1;

  typedef struct packed {
    logic signed [31:0] center_altitude;
    logic [30:0]        center_thickness;
    logic signed [31:0] altitude_one;
    logic [30:0]        thickness_one;
    logic signed [31:0] altitude_two;
    logic [30:0]        thickness_two;
    logic signed [31:0] altitude_three;
    logic [30:0]        thickness_three;
    logic signed [31:0] altitude_four;
    logic [30:0]        thickness_four;
  } in_item_t;

  typedef struct packed {
    logic [30:0] flow_one;
    logic [30:0] flow_two;
    logic [30:0] flow_three;
    logic [30:0] flow_four;
    logic [30:0] total_outflow;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       sum;
    logic       div;
    logic       elim;
    logic       diff;
    logic       mlo;
    logic       mhi;
    logic       acc;
    logic       out_load;
    logic [1:0] nb;
  } dom_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic again;
  } dom_sts_t;

endpackage

// File: hdl/dom_ctrl.sv
// Controller for the debris outflow block: sequences rounds, divide, flows.
// Depends on dom_pkg.
`timescale 1ns / 1ps
module dom_ctrl
  import dom_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dom_sts_t sts,
  output dom_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIV, S_ELIM, S_DIFF, S_MLO, S_MHI, S_ACC, S_DONE
  } state_t;

  state_t     state;
  logic [3:0] div_cnt;
  logic [1:0] nb;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.nb       = nb;
    cmd.load     = accept;
    cmd.sum      = (state == S_SUM);
    cmd.div      = (state == S_DIV);
    cmd.elim     = (state == S_ELIM);
    cmd.diff     = (state == S_DIFF);
    cmd.mlo      = (state == S_MLO);
    cmd.mhi      = (state == S_MHI);
    cmd.acc      = (state == S_ACC);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  // State, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      nb        <= '0;
      out_valid <= 1'b0;
    end else begin
      // New result wins over the drain of the old one
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_SUM;
        end
        S_SUM: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == 4'(DIV_STEPS - 1)) state <= S_ELIM;
          else div_cnt <= div_cnt + 4'd1;
        end
        S_ELIM: begin
          nb <= '0;
          if (sts.again) state <= S_SUM;
          else state <= S_DIFF;
        end
        S_DIFF: state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_ACC;
        S_ACC: begin
          nb <= nb + 2'd1;
          if (nb == 2'd3) state <= S_DONE;
          else state <= S_DIFF;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/dom_datapath.sv
// Datapath for the debris outflow block: levels, round sum, 4-bit-per-step
// divider, elimination, shared multiplier and result register. Uses dom_pkg.
`timescale 1ns / 1ps
module dom_datapath
  import dom_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REL_W-1:0] cfg_data,
  input  dom_cmd_t         cmd,
  output dom_sts_t         sts,
  output out_item_t        out_result
);

  logic [EPS_W-1:0]        epsilon;
  logic [REL_W-1:0]        relaxation;
  logic signed [LVL_W-1:0] level [NBHD];
  logic [NBHD-1:0]         gone;
  logic signed [AMT_W-1:0] amount;
  logic                    neg;
  logic [2:0]              divisor;
  logic [2:0]              rem;
  logic [DIV_W-1:0]        dq;
  logic signed [AVG_W-1:0] avg;
  logic signed [AVG_W-1:0] diff;
  logic [PP_W-1:0]         plo;
  logic [PP_W-1:0]         phi;
  logic [FLOW_W-1:0]       flow [4];
  logic [FLOW_W-1:0]       total;

  logic signed [SUM_W-1:0] sum_c;
  logic [2:0]              count_c;
  logic [SUM_W-1:0]        mag_c;
  logic [2:0]              rem_c;
  logic [DIV_W-1:0]        dq_c;
  logic [3:0]              rem4;
  logic signed [AVG_W-1:0] avg_c;
  logic [NBHD-1:0]         ge_c;
  logic [PROD_W-1:0]       prod_c;
  logic [PROD_W-17:0]      shr_c;
  logic [FLOW_W-1:0]       flow_c;
  logic [FLOW_W:0]         tsum_c;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon    <= EPS_RESET;
      relaxation <= REL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_EPSILON) epsilon <= cfg_data[EPS_W-1:0];
      else relaxation <= cfg_data;
    end
  end

  // Round sum over cells still in play
  always_comb begin
    sum_c   = SUM_W'(amount);
    count_c = '0;
    for (int n = 0; n < NBHD; n++) begin
      if (!gone[n]) begin
        sum_c   = sum_c + SUM_W'(level[n]);
        count_c = count_c + 3'd1;
      end
    end
    mag_c = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
  end

  // Four restoring divide steps
  always_comb begin
    rem_c = rem;
    dq_c  = dq;
    rem4  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem4 = {rem_c, dq_c[DIV_W-1]};
      if (rem4 >= {1'b0, divisor}) begin
        dq_c  = {dq_c[DIV_W-2:0], 1'b1};
        rem_c = 3'(rem4 - {1'b0, divisor});
      end else begin
        dq_c  = {dq_c[DIV_W-2:0], 1'b0};
        rem_c = rem4[2:0];
      end
    end
  end

  // Signed average, and cells at or above it
  always_comb begin
    avg_c = neg ? -$signed(dq[AVG_W-1:0]) : $signed(dq[AVG_W-1:0]);
    for (int n = 0; n < NBHD; n++) begin
      ge_c[n] = !gone[n] && (avg_c <= AVG_W'(level[n]));
    end
  end
  assign sts.again = |ge_c;

  // Flow from the two partial products, saturated; running total saturated
  always_comb begin
    prod_c = {1'b0, phi, {LO_W{1'b0}}} + PROD_W'(plo);
    shr_c  = prod_c[PROD_W-1:16];
    flow_c = (shr_c > (PROD_W-16)'(FLOW_MAX)) ? FLOW_MAX : shr_c[FLOW_W-1:0];
    if (gone[3'(cmd.nb) + 3'd1]) flow_c = '0;
    tsum_c = {1'b0, total} + {1'b0, flow_c};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level[0] <= LVL_W'(in_item.center_altitude) + LVL_W'(epsilon);
      level[1] <= LVL_W'(in_item.altitude_one)   + LVL_W'(in_item.thickness_one);
      level[2] <= LVL_W'(in_item.altitude_two)   + LVL_W'(in_item.thickness_two);
      level[3] <= LVL_W'(in_item.altitude_three) + LVL_W'(in_item.thickness_three);
      level[4] <= LVL_W'(in_item.altitude_four)  + LVL_W'(in_item.thickness_four);
      amount   <= $signed({1'b0, in_item.center_thickness}) - AMT_W'(epsilon);
      gone     <= '0;
      total    <= '0;
    end
    if (cmd.sum) begin
      neg     <= sum_c[SUM_W-1];
      dq      <= DIV_W'(mag_c);
      rem     <= '0;
      divisor <= (count_c == 3'd0) ? 3'd1 : count_c;
    end
    if (cmd.div) begin
      dq  <= dq_c;
      rem <= rem_c;
    end
    if (cmd.elim) begin
      avg  <= avg_c;
      gone <= gone | ge_c;
    end
    if (cmd.diff) diff <= avg - AVG_W'(level[3'(cmd.nb) + 3'd1]);
    if (cmd.mlo) plo <= PP_W'(diff[LO_W-1:0] * relaxation);
    if (cmd.mhi) phi <= PP_W'(diff[AVG_W-1:LO_W] * relaxation);
    if (cmd.acc) begin
      flow[cmd.nb] <= flow_c;
      total        <= tsum_c[FLOW_W] ? FLOW_MAX : tsum_c[FLOW_W-1:0];
    end
    if (cmd.out_load) begin
      out_result.flow_one      <= flow[0];
      out_result.flow_two      <= flow[1];
      out_result.flow_three    <= flow[2];
      out_result.flow_four     <= flow[3];
      out_result.total_outflow <= total;
    end
  end

endmodule

// File: hdl/debris_outflow_minimization.sv
// Top level of the debris outflow block: controller plus datapath.
// Depends on dom_pkg, dom_ctrl and dom_datapath.
`timescale 1ns / 1ps
// Computes the outflow from one cell to its four neighbours by the
// minimization-of-differences rule. Each elimination round runs one sum,
// ten steps of a divider that resolves four quotient bits per cycle and
// one compare; one to six rounds run, then a shared multiplier forms each
// of the four flows through the difference, low product, high product and
// accumulate states. A new item is taken while the previous result still
// waits on the output register.
// Configuration writes are always ready.
module debris_outflow_minimization
  import dom_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [REL_W-1:0] cfg_data
);

  dom_cmd_t cmd;
  dom_sts_t sts;

  assign cfg_ready = 1'b1;

  dom_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dom_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_result (out_result)
  );

endmodule
